// ===== sv/eul_pkg.sv =====
// ----------------------------------------------------------------------------
// eul_pkg: shared types, constants and helpers for the Euler point rotator
// Holds the CORDIC arctangent table, datapath widths and the stage records.
// ----------------------------------------------------------------------------
package eul_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_STEPS      = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_STEPS) ?
                                     TRIG_ITERATIONS : ATAN_STEPS;

    localparam int CW  = 34;        // CORDIC x/y and trig values, Q2.30 plus headroom
    localparam int RW  = 33;        // CORDIC residual phase
    localparam int PW  = 36;        // wide coordinate, Q16.16 plus growth
    localparam int MW  = PW + CW;   // product width
    localparam int IW  = 5;         // step index width

    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [MW-1:0] HALF_Q30     = MW'(64'sd536870912);

    localparam logic signed [PW-1:0] COORD_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] COORD_MIN = PW'(-64'sd2147483648);

    // rotation roles of a rotation cell
    localparam logic [1:0] ROLE_X = 2'd0;
    localparam logic [1:0] ROLE_Y = 2'd1;
    localparam logic [1:0] ROLE_Z = 2'd2;

    typedef struct packed {
        logic [2:0][CW-1:0] cx;
        logic [2:0][CW-1:0] cy;
        logic [2:0][RW-1:0] res;
        logic [2:0]         flip;
        logic [2:0][31:0]   pt;
    } cordic_t;

    typedef struct packed {
        logic [2:0][PW-1:0] pt;
        logic [2:0][CW-1:0] cs;
        logic [2:0][CW-1:0] sn;
    } rot_t;

    function automatic logic [RW-1:0] atan_phase(input logic [IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return {1'b0, v};
    endfunction

    // round a Q16.16 x Q2.30 product back to Q16.16 (floor of p + half)
    function automatic logic signed [PW-1:0] round_q30(input logic signed [MW-1:0] p);
        logic signed [MW-1:0] t;
        t = p + HALF_Q30;
        return t[PW+29:30];
    endfunction

endpackage

// ===== sv/euler_xyz_point_rotation.sv =====
// ----------------------------------------------------------------------------
// euler_xyz_point_rotation: rotate a Q16.16 point by three Euler angles
// Rotates about x, then y, then z (z angle applied negated), saturates.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is taken every clock unless the pipe holds, and
// each result passes through the row of CORDIC cells (one micro-rotation per
// cell for all three angles at once), three rotation cells of two stages
// each, and the output register. The whole pipe advances together; it holds
// while a result sits in the output register and m_tready is low. Angles are
// 16-bit fractions of a half turn (32768 = pi); coordinates are signed Q16.16.
// Any coordinate that leaves the 32-bit range is clipped and m_tuser is raised
// for that beat.
module euler_xyz_point_rotation
    import eul_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // angle_about_x[15:0], angle_about_y[31:16], angle_about_z[47:32],
    // point_x[79:48], point_y[111:80], point_z[143:112]
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rotated_x[31:0], rotated_y[63:32], rotated_z[95:64]
    output logic [95:0]  m_tdata,
    // saturated[0]
    output logic         m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int LAT = CORDIC_STEPS + 6;

    logic            ce;
    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vld_next;
    logic            m_tvalid_reg;
    logic [95:0]     m_tdata_reg;
    logic            m_tuser_reg;
    logic [95:0]     m_tdata_next;
    logic            m_tuser_next;

    cordic_t         cch [CORDIC_STEPS+1];
    rot_t            rch [4];

    // advance the whole pipe unless a finished beat is stuck at the output
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // seed the CORDIC lanes: move angle to phase, fold outer half-plane by pi
    always_comb begin
        logic signed [15:0] ang;
        cch[0] = '0;
        for (int k = 0; k < 3; k++) begin
            ang              = s_tdata[16*k +: 16];
            cch[0].flip[k]   = (ang < -16'sd16384) || (ang > 16'sd16384);
            cch[0].res[k]    = {ang[15] ^ cch[0].flip[k], ang[15] ^ cch[0].flip[k],
                                ang[14:0], 16'd0};
            cch[0].cx[k]     = INV_GAIN_Q30;
            cch[0].cy[k]     = '0;
            cch[0].pt[k]     = s_tdata[48 + 32*k +: 32];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
            eul_cordic_cell u_cell (
                .aclk     (aclk),
                .ce       (ce),
                .step_idx (IW'(g)),
                .d_in     (cch[g]),
                .d_out    (cch[g+1])
            );
        end
    endgenerate

    // undo the pi fold and widen the point
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rch[0].cs[k] = cch[CORDIC_STEPS].flip[k] ? -cch[CORDIC_STEPS].cx[k]
                                                     :  cch[CORDIC_STEPS].cx[k];
            rch[0].sn[k] = cch[CORDIC_STEPS].flip[k] ? -cch[CORDIC_STEPS].cy[k]
                                                     :  cch[CORDIC_STEPS].cy[k];
            rch[0].pt[k] = PW'($signed(cch[CORDIC_STEPS].pt[k]));
        end
    end

    eul_rot_cell u_rot_x (.aclk(aclk), .ce(ce), .role(ROLE_X), .d_in(rch[0]), .d_out(rch[1]));
    eul_rot_cell u_rot_y (.aclk(aclk), .ce(ce), .role(ROLE_Y), .d_in(rch[1]), .d_out(rch[2]));
    eul_rot_cell u_rot_z (.aclk(aclk), .ce(ce), .role(ROLE_Z), .d_in(rch[2]), .d_out(rch[3]));

    // clip each coordinate to 32 bits and flag the beat
    always_comb begin
        logic signed [PW-1:0] v;
        m_tuser_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v = rch[3].pt[k];
            if (v > COORD_MAX) begin
                m_tdata_next[32*k +: 32] = COORD_MAX[31:0];
                m_tuser_next             = 1'b1;
            end else if (v < COORD_MIN) begin
                m_tdata_next[32*k +: 32] = COORD_MIN[31:0];
                m_tuser_next             = 1'b1;
            end else begin
                m_tdata_next[32*k +: 32] = v[31:0];
            end
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a flagged beat must carry at least one clipped coordinate
    a_sat_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[31:0]  == COORD_MAX[31:0]) || (m_tdata[31:0]  == COORD_MIN[31:0]) ||
            (m_tdata[63:32] == COORD_MAX[31:0]) || (m_tdata[63:32] == COORD_MIN[31:0]) ||
            (m_tdata[95:64] == COORD_MAX[31:0]) || (m_tdata[95:64] == COORD_MIN[31:0]))
        else $error("saturation flag without a clipped coordinate");

    // the pipe stalls only behind an untaken result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no output back-pressure");

    // a stalled pipe keeps its valid pattern
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipeline valids moved during stall");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && (vld_reg == '0))
        else $error("pipeline not empty after reset");

endmodule

// ===== sv/eul_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// eul_cordic_cell: one CORDIC micro-rotation for the three angle lanes
// Registers its result and hands the point along unchanged.
// ----------------------------------------------------------------------------
module eul_cordic_cell
    import eul_pkg::*;
(
    input  logic            aclk,
    input  logic            ce,
    input  logic [IW-1:0]   step_idx,
    input  cordic_t         d_in,
    output cordic_t         d_out
);

    cordic_t d_next;
    cordic_t d_reg;
    logic [RW-1:0] ang;

    always_comb begin
        ang    = atan_phase(step_idx);
        d_next = d_in;
        for (int k = 0; k < 3; k++) begin
            if (!d_in.res[k][RW-1]) begin
                d_next.cx[k]  = $signed(d_in.cx[k]) - ($signed(d_in.cy[k]) >>> step_idx);
                d_next.cy[k]  = $signed(d_in.cy[k]) + ($signed(d_in.cx[k]) >>> step_idx);
                d_next.res[k] = d_in.res[k] - ang;
            end else begin
                d_next.cx[k]  = $signed(d_in.cx[k]) + ($signed(d_in.cy[k]) >>> step_idx);
                d_next.cy[k]  = $signed(d_in.cy[k]) - ($signed(d_in.cx[k]) >>> step_idx);
                d_next.res[k] = d_in.res[k] + ang;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== sv/eul_rot_cell.sv =====
// ----------------------------------------------------------------------------
// eul_rot_cell: one planar rotation of the point, two register stages
// Multiply in the first stage, round and combine in the second.
// ----------------------------------------------------------------------------
module eul_rot_cell
    import eul_pkg::*;
(
    input  logic        aclk,
    input  logic        ce,
    input  logic [1:0]  role,
    input  rot_t        d_in,
    output rot_t        d_out
);

    logic signed [PW-1:0] a, b;
    logic signed [CW-1:0] c, s;
    logic signed [MW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    rot_t                 mid_reg;
    rot_t                 d_next;
    rot_t                 d_reg;
    logic signed [PW-1:0] p, q;

    // pick the coordinate pair and trig lane for this axis
    always_comb begin
        unique case (role)
            ROLE_X: begin
                a = d_in.pt[1]; b = d_in.pt[2];
                c = d_in.cs[0]; s = d_in.sn[0];
            end
            ROLE_Y: begin
                a = d_in.pt[2]; b = d_in.pt[0];
                c = d_in.cs[1]; s = d_in.sn[1];
            end
            default: begin
                a = d_in.pt[1]; b = d_in.pt[0];
                c = d_in.cs[2]; s = -$signed(d_in.sn[2]);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ac_reg  <= MW'(a) * MW'(c);
            bs_reg  <= MW'(b) * MW'(s);
            as_reg  <= MW'(a) * MW'(s);
            bc_reg  <= MW'(b) * MW'(c);
            mid_reg <= d_in;
        end
    end

    always_comb begin
        p      = round_q30(ac_reg) - round_q30(bs_reg);
        q      = round_q30(as_reg) + round_q30(bc_reg);
        d_next = mid_reg;
        unique case (role)
            ROLE_X: begin
                d_next.pt[1] = p; d_next.pt[2] = q;
            end
            ROLE_Y: begin
                d_next.pt[2] = p; d_next.pt[0] = q;
            end
            default: begin
                d_next.pt[1] = p; d_next.pt[0] = q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
